@@ hw/rtl/hsl_pkg.sv @@
// shared types and constants for the rgb to hsl converter
package hsl_pkg;

    localparam int NUM_CELLS = 8;
    localparam int NUM_LANES = 4;

    localparam logic [1:0] LANE_SAT = 2'd0;
    localparam logic [1:0] LANE_DR  = 2'd1;
    localparam logic [1:0] LANE_DG  = 2'd2;
    localparam logic [1:0] LANE_DB  = 2'd3;

    localparam logic [1:0] GRP_RED   = 2'd0;
    localparam logic [1:0] GRP_GREEN = 2'd1;
    localparam logic [1:0] GRP_BLUE  = 2'd2;

    localparam logic [7:0] HUE_GREY  = 8'd170;
    localparam logic [7:0] HUE_THIRD = 8'd85;
    localparam logic [7:0] HUE_SIXTH = 8'd42;
    localparam logic [7:0] HSL_FULL  = 8'd255;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] lightness;
    } t_hsl;

    typedef struct packed {
        logic [8:0] den;
        logic [8:0] rem;
        logic [7:0] low;
        logic [7:0] quo;
    } t_lane;

    typedef struct packed {
        logic                       vld;
        logic                       grey;
        logic [7:0]                 light;
        logic [1:0]                 grp;
        t_lane [NUM_LANES-1:0]      lane;
    } t_stage;

endpackage

@@ hw/rtl/hsl_prep.sv @@
// input stage: max, min, lightness and divider operands
module hsl_prep import hsl_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_pixel i_pix,
    output t_stage o_stage
);

    t_stage r_stage;
    t_stage n_stage;

    logic [7:0]  mx;
    logic [7:0]  mn;
    logic [8:0]  sum;
    logic [7:0]  spread;
    logic [8:0]  den;
    logic [16:0] sat_num;
    logic [13:0] dr_num;
    logic [13:0] dg_num;
    logic [13:0] db_num;
    logic [1:0]  grp;

    always_comb begin
        mx = i_pix.red;
        mn = i_pix.red;
        if (i_pix.green > mx) mx = i_pix.green;
        if (i_pix.blue > mx) mx = i_pix.blue;
        if (i_pix.green < mn) mn = i_pix.green;
        if (i_pix.blue < mn) mn = i_pix.blue;
        sum    = {1'b0, mx} + {1'b0, mn};
        spread = mx - mn;
        if (sum <= 9'd254) begin
            den = sum;
        end else begin
            den = 9'd510 - sum;
        end
        sat_num = ({9'd0, spread} << 8) - {9'd0, spread} + {9'd0, den[8:1]};
        dr_num  = 14'((mx - i_pix.red) * HUE_SIXTH) + {7'd0, spread[7:1]};
        dg_num  = 14'((mx - i_pix.green) * HUE_SIXTH) + {7'd0, spread[7:1]};
        db_num  = 14'((mx - i_pix.blue) * HUE_SIXTH) + {7'd0, spread[7:1]};
        if (i_pix.red == mx) begin
            grp = GRP_RED;
        end else if (i_pix.green == mx) begin
            grp = GRP_GREEN;
        end else begin
            grp = GRP_BLUE;
        end

        n_stage       = r_stage;
        n_stage.vld   = i_valid;
        n_stage.grey  = (spread == 8'd0);
        n_stage.light = 8'((10'({1'b0, sum}) + 10'd1) >> 1);
        n_stage.grp   = grp;
        n_stage.lane[LANE_SAT] = '{den: den, rem: sat_num[16:8], low: sat_num[7:0], quo: 8'd0};
        n_stage.lane[LANE_DR]  = '{den: {1'b0, spread}, rem: {3'd0, dr_num[13:8]},
                                   low: dr_num[7:0], quo: 8'd0};
        n_stage.lane[LANE_DG]  = '{den: {1'b0, spread}, rem: {3'd0, dg_num[13:8]},
                                   low: dg_num[7:0], quo: 8'd0};
        n_stage.lane[LANE_DB]  = '{den: {1'b0, spread}, rem: {3'd0, db_num[13:8]},
                                   low: db_num[7:0], quo: 8'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

@@ hw/rtl/hsl_div_cell.sv @@
// one restoring division step for every lane, registered
module hsl_div_cell import hsl_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_stage i_stage,
    output t_stage o_stage
);

    t_stage r_stage;
    t_stage n_stage;

    always_comb begin
        logic [9:0] trial;
        n_stage = i_stage;
        for (int k = 0; k < NUM_LANES; k++) begin
            trial = {i_stage.lane[k].rem, i_stage.lane[k].low[7]};
            if (trial >= {1'b0, i_stage.lane[k].den}) begin
                n_stage.lane[k].rem = 9'(trial - {1'b0, i_stage.lane[k].den});
                n_stage.lane[k].quo = {i_stage.lane[k].quo[6:0], 1'b1};
            end else begin
                n_stage.lane[k].rem = trial[8:0];
                n_stage.lane[k].quo = {i_stage.lane[k].quo[6:0], 1'b0};
            end
            n_stage.lane[k].low = {i_stage.lane[k].low[6:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

@@ hw/rtl/hsl_post.sv @@
// output stage: hue assembly and result register
module hsl_post import hsl_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_stage i_stage,
    output logic   o_valid,
    output t_hsl   o_hsl
);

    logic r_valid;
    t_hsl r_hsl;
    t_hsl n_hsl;

    logic signed [9:0] hue;
    logic signed [9:0] dr;
    logic signed [9:0] dg;
    logic signed [9:0] db;

    always_comb begin
        dr = signed'({2'd0, i_stage.lane[LANE_DR].quo});
        dg = signed'({2'd0, i_stage.lane[LANE_DG].quo});
        db = signed'({2'd0, i_stage.lane[LANE_DB].quo});
        case (i_stage.grp)
            GRP_RED:   hue = db - dg;
            GRP_GREEN: hue = signed'({2'd0, HUE_THIRD}) + dr - db;
            default:   hue = signed'({2'd0, HUE_GREY}) + dg - dr;
        endcase
        if (hue < 0) begin
            hue = hue + signed'({2'd0, HSL_FULL});
        end
        n_hsl.lightness = i_stage.light;
        if (i_stage.grey) begin
            n_hsl.hue        = HUE_GREY;
            n_hsl.saturation = 8'd0;
        end else begin
            n_hsl.hue        = hue[7:0];
            n_hsl.saturation = i_stage.lane[LANE_SAT].quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_stage.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hsl <= n_hsl;
        end
    end

    assign o_valid = r_valid;
    assign o_hsl   = r_hsl;

endmodule

@@ hw/rtl/rgb_to_hsl_pixel_converter.sv @@
// top level of the rgb to hsl pixel converter
// Converts one 8-bit RGB pixel per clock into hue, saturation and lightness,
// each scaled 0..255 (hue 170 and saturation 0 for grey). The pipeline is an
// input stage, a row of eight division cells that each resolve one quotient
// bit for the saturation and the three hue deltas, and an output register. A
// new request is taken every cycle; the whole pipeline holds while a waiting
// result is stalled at the output.
module rgb_to_hsl_pixel_converter import hsl_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_stall,
    input  t_pixel i_pix,
    output logic   o_valid,
    input  logic   i_stall,
    output t_hsl   o_hsl
);

    logic   en;
    t_stage stage [NUM_CELLS+1];

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    hsl_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_pix   (i_pix),
        .o_stage (stage[0])
    );

    for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
        hsl_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_stage (stage[c]),
            .o_stage (stage[c+1])
        );
    end

    hsl_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_stage (stage[NUM_CELLS]),
        .o_valid (o_valid),
        .o_hsl   (o_hsl)
    );

endmodule

@@ test/testbench.sv @@
// testbench for the rgb to hsl pixel converter: predicts each result and compares
`timescale 1ns / 1ps

module testbench;
    import hsl_pkg::*;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_stall;
    t_pixel i_pix;
    logic   o_valid;
    logic   i_stall;
    t_hsl   o_hsl;

    t_hsl   expected_hsl[$];
    int     mismatch_count;
    int     result_count;
    int     request_count;
    bit     sender_idle_on;
    bit     receiver_idle_on;
    bit     hold_off_req;
    bit     hold_off_busy;
    int     hold_off_len;

    rgb_to_hsl_pixel_converter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_pix   (i_pix),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_hsl   (o_hsl)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_hsl predict_hsl(t_pixel p);
        int r;
        int g;
        int b;
        int mx;
        int mn;
        int sum;
        int spread;
        int light;
        int sat;
        int hue;
        int den;
        int dr;
        int dg;
        int db;
        t_hsl res;
        r = p.red;
        g = p.green;
        b = p.blue;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        sum = mx + mn;
        spread = mx - mn;
        light = (sum * 255 + 255) / 510;
        if (spread == 0) begin
            sat = 0;
            hue = HUE_GREY;
        end else begin
            if (light <= 127) begin
                sat = (spread * 255 + sum / 2) / sum;
            end else begin
                den = 510 - sum;
                if (den <= 0) den = 1;
                sat = (spread * 255 + den / 2) / den;
            end
            dr = ((mx - r) * HUE_SIXTH + spread / 2) / spread;
            dg = ((mx - g) * HUE_SIXTH + spread / 2) / spread;
            db = ((mx - b) * HUE_SIXTH + spread / 2) / spread;
            if (r == mx) hue = db - dg;
            else if (g == mx) hue = HUE_THIRD + dr - db;
            else hue = 170 + dg - dr;
            if (hue < 0) hue += 255;
            if (hue > 255) hue -= 255;
        end
        if (sat > 255) sat = 255;
        if (light > 255) light = 255;
        res.hue = hue[7:0];
        res.saturation = sat[7:0];
        res.lightness = light[7:0];
        return res;
    endfunction

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        t_pixel p;
        int gap;
        p.red = r;
        p.green = g;
        p.blue = b;
        if (sender_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pix <= p;
        expected_hsl.push_back(predict_hsl(p));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        request_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_hsl exp_hsl;
        if (i_rst_n && o_valid && !i_stall) begin
            result_count++;
            if (expected_hsl.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result hue=%0d sat=%0d light=%0d",
                             o_hsl.hue, o_hsl.saturation, o_hsl.lightness);
            end else begin
                exp_hsl = expected_hsl.pop_front();
                if (o_hsl.hue !== exp_hsl.hue || o_hsl.saturation !== exp_hsl.saturation
                        || o_hsl.lightness !== exp_hsl.lightness) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected h=%0d s=%0d l=%0d got h=%0d s=%0d l=%0d",
                                 exp_hsl.hue, exp_hsl.saturation, exp_hsl.lightness,
                                 o_hsl.hue, o_hsl.saturation, o_hsl.lightness);
                end
            end
        end
    end

    // receiver stall, with random bursts and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            hold_off_len <= 0;
            hold_off_busy <= 1'b0;
        end else if (hold_off_req && !hold_off_busy) begin
            hold_off_busy <= 1'b1;
            hold_off_len <= 40;
            i_stall <= 1'b1;
        end else if (hold_off_len > 1) begin
            hold_off_len <= hold_off_len - 1;
        end else if (hold_off_len == 1) begin
            hold_off_len <= 0;
            i_stall <= 1'b0;
        end else if (receiver_idle_on && $urandom_range(0, 7) == 0) begin
            hold_off_len <= $urandom_range(1, 8);
            i_stall <= 1'b1;
        end
        if (i_rst_n && !hold_off_req) hold_off_busy <= 1'b0;
    end

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_hsl.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_extremes();
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd127, 8'd127, 8'd127);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd1, 8'd0);
        send_pixel(8'd200, 8'd200, 8'd10);
        send_pixel(8'd10, 8'd200, 8'd200);
        send_pixel(8'd128, 8'd127, 8'd127);
        send_pixel(8'd127, 8'd126, 8'd128);
        send_pixel(8'd170, 8'd85, 8'd85);
        send_pixel(8'd50, 8'd100, 8'd150);
    endtask

    task automatic test_random(input int count);
        int kind;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        repeat (count) begin
            kind = $urandom_range(0, 9);
            r = 8'($urandom_range(0, 255));
            g = 8'($urandom_range(0, 255));
            b = 8'($urandom_range(0, 255));
            if (kind == 0) begin
                g = r;
                b = r;
            end else if (kind == 1) begin
                g = r;
            end else if (kind == 2) begin
                b = g;
            end else if (kind == 3) begin
                r = r | 8'h80;
                g = 8'(r - $urandom_range(0, 3));
                b = 8'(r - $urandom_range(0, 3));
            end
            send_pixel(r, g, b);
        end
    endtask

    task automatic test_backpressure();
        hold_off_req = 1'b1;
        repeat (30) send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)));
        hold_off_req = 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_pix = '0;
        mismatch_count = 0;
        result_count = 0;
        request_count = 0;
        sender_idle_on = 1'b0;
        receiver_idle_on = 1'b0;
        hold_off_req = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        sender_idle_on = 1'b1;
        receiver_idle_on = 1'b1;
        test_random(600);
        test_backpressure();
        test_random(300);
        sender_idle_on = 1'b0;
        receiver_idle_on = 1'b0;
        test_random(100);
        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("covered %0d pixels: grey, primaries, ties, bright and dark ranges,",
                 request_count);
        $display("random idling on both sides and a long output hold-off; %0d results",
                 result_count);
        if (mismatch_count == 0 && expected_hsl.size() == 0) begin
            $display("** rgb_to_hsl_pixel_converter: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count, expected_hsl.size());
            $display("** rgb_to_hsl_pixel_converter: FAILED **");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout");
        $display("** rgb_to_hsl_pixel_converter: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/hsl_pkg.sv
hw/rtl/hsl_prep.sv
hw/rtl/hsl_div_cell.sv
hw/rtl/hsl_post.sv
hw/rtl/rgb_to_hsl_pixel_converter.sv
test/testbench.sv
